>>> design/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// shared types, register map and helpers of the frame transition compositor
// ----------------------------------------------------------------------------
package ftc_pkg;

	// coordinate counters and clamped frame dimensions
	localparam int COORD_BITS    = 12;
	localparam int DIM_BITS      = COORD_BITS + 1;
	localparam int CFG_DIM_BITS  = 13;
	localparam int PROG_BITS     = 9;
	localparam int PROD_BITS     = DIM_BITS + PROG_BITS;
	localparam int THR_BITS      = PROD_BITS - 8;
	localparam int CHAN_BITS     = 8;
	localparam int NUM_CHAN      = 4;
	localparam int PIX_BITS      = CHAN_BITS * NUM_CHAN;

	localparam logic [PROG_BITS-1:0]    FULL_PROGRESS  = 9'd256;
	localparam logic [CFG_DIM_BITS-1:0] DEFAULT_WIDTH  = 13'd1920;
	localparam logic [CFG_DIM_BITS-1:0] DEFAULT_HEIGHT = 13'd1080;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_IDX_BITS-1:0] REG_KIND      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROGRESS  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd4;

	// transition kinds and wipe directions
	localparam logic [2:0] KIND_DISSOLVE = 3'd0;
	localparam logic [2:0] KIND_WIPE     = 3'd1;

	localparam logic [2:0] DIR_LEFT_RIGHT = 3'd0;
	localparam logic [2:0] DIR_RIGHT_LEFT = 3'd1;
	localparam logic [2:0] DIR_TOP_BOTTOM = 3'd2;
	localparam logic [2:0] DIR_BOTTOM_TOP = 3'd3;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel_first;
		logic [PIX_BITS-1:0] pixel_second;
	} ftc_in_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel_out;
		logic                line_end;
		logic                frame_end;
	} ftc_out_t;

	// zero becomes one, anything above the counter range saturates
	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_DIM_BITS-1:0] d);
		logic [DIM_BITS-1:0] res;
		if (d == '0) begin
			res = DIM_BITS'(1);
		end else if (32'(d) > (32'd1 << COORD_BITS)) begin
			res = DIM_BITS'(32'd1 << COORD_BITS);
		end else begin
			res = DIM_BITS'(d);
		end
		return res;
	endfunction

endpackage

>>> design/frame_transition_compositor_core.sv
// ----------------------------------------------------------------------------
// frame_transition_compositor_core
// cross-fade and straight wipe of two co-located rgba pixel streams
// ----------------------------------------------------------------------------
// usage
//   src channel: one item holds the co-located pixel pair of the outgoing and
//   incoming frame, in raster order; the block tracks column and row itself
//   dst channel: one item per input item with the composited pixel and the
//   line_end / frame_end markers derived from the configured geometry
//   cfg channel: cfg_ready is always high; write registers only while idle
//   latency: result valid one cycle after the input accept edge, so the
//   result is taken two edges after its input at the earliest (input
//   register, then result register behind the blend / wipe logic)
//   throughput: one item per clock, set by the single pass through the
//   channel multipliers and the split-line multiplier
//   stall: a stall on dst holds the result register; src stall rises only
//   when both registers hold items and dst stalls, so no item is dropped
//   reset: counters at column 0 / row 0, dissolve, progress 0, 1920x1080
// ----------------------------------------------------------------------------
module frame_transition_compositor_core
	import ftc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// pixel pair input
	input  logic                     src_valid,
	output logic                     src_stall,
	input  ftc_in_t                  src_item,
	// composited output
	output logic                     dst_valid,
	input  logic                     dst_stall,
	output ftc_out_t                 dst_item,
	// register writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// configuration registers
	logic [2:0]              kind_q;
	logic [2:0]              direction_q;
	logic [PROG_BITS-1:0]    progress_q;
	logic [CFG_DIM_BITS-1:0] width_q;
	logic [CFG_DIM_BITS-1:0] height_q;

	// raster position of the next accepted item
	logic [COORD_BITS-1:0] column_q;
	logic [COORD_BITS-1:0] row_q;

	// input stage
	logic                  valid_s1;
	ftc_in_t               item_s1;
	logic [COORD_BITS-1:0] column_s1;
	logic [COORD_BITS-1:0] row_s1;
	logic                  line_end_s1;
	logic                  frame_end_s1;

	// result stage
	logic     valid_s2;
	ftc_out_t item_s2;

	logic load_s1;
	logic load_s2;
	logic src_accept;

	logic [DIM_BITS-1:0]  width_eff;
	logic [DIM_BITS-1:0]  height_eff;
	logic [DIM_BITS-1:0]  column_inc;
	logic [DIM_BITS-1:0]  row_inc;
	logic                 line_end_in;
	logic                 frame_end_in;

	logic [PROG_BITS-1:0] prog_eff;
	logic [PROG_BITS-1:0] prog_inv;
	logic                 wipe_mode;
	logic                 vertical;
	logic                 reverse;
	logic [DIM_BITS-1:0]  dim_sel;
	logic [PROG_BITS-1:0] prog_sel;
	logic [PROD_BITS-1:0] split_prod;
	logic [THR_BITS-1:0]  split_pos;
	logic [THR_BITS-1:0]  coord_sel;
	logic                 take_second;
	logic [PIX_BITS-1:0]  fade_pix;
	logic [PIX_BITS-1:0]  result_pix;

	// flow control: result register drains or is empty, input register follows
	assign load_s2    = !valid_s2 || !dst_stall;
	assign load_s1    = !valid_s1 || load_s2;
	assign src_stall  = !load_s1;
	assign src_accept = src_valid && load_s1;
	assign cfg_ready  = 1'b1;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_DISSOLVE;
			direction_q <= DIR_LEFT_RIGHT;
			progress_q  <= '0;
			width_q     <= DEFAULT_WIDTH;
			height_q    <= DEFAULT_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KIND:      kind_q      <= cfg_data[2:0];
				REG_DIRECTION: direction_q <= cfg_data[2:0];
				REG_PROGRESS:  progress_q  <= cfg_data[PROG_BITS-1:0];
				REG_WIDTH:     width_q     <= cfg_data[CFG_DIM_BITS-1:0];
				REG_HEIGHT:    height_q    <= cfg_data[CFG_DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// raster tracking at accept time; a column at or past the last one ends
	// the line even when the geometry shrank mid-frame
	assign width_eff    = clamp_dim(width_q);
	assign height_eff   = clamp_dim(height_q);
	assign column_inc   = DIM_BITS'(column_q) + DIM_BITS'(1);
	assign row_inc      = DIM_BITS'(row_q) + DIM_BITS'(1);
	assign line_end_in  = column_inc >= width_eff;
	assign frame_end_in = line_end_in && (row_inc >= height_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (src_accept) begin
			if (line_end_in) begin
				column_q <= '0;
				row_q    <= frame_end_in ? '0 : row_inc[COORD_BITS-1:0];
			end else begin
				column_q <= column_inc[COORD_BITS-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_accept) begin
			item_s1      <= src_item;
			column_s1    <= column_q;
			row_s1       <= row_q;
			line_end_s1  <= line_end_in;
			frame_end_s1 <= frame_end_in;
		end
	end

	// progress saturates at 1.0
	assign prog_eff = (progress_q > FULL_PROGRESS) ? FULL_PROGRESS : progress_q;
	assign prog_inv = FULL_PROGRESS - prog_eff;

	// straight wipes share one split-line multiplier
	assign wipe_mode = (kind_q == KIND_WIPE) &&
		(direction_q == DIR_LEFT_RIGHT || direction_q == DIR_RIGHT_LEFT ||
		 direction_q == DIR_TOP_BOTTOM || direction_q == DIR_BOTTOM_TOP);
	assign vertical  = (direction_q == DIR_TOP_BOTTOM) || (direction_q == DIR_BOTTOM_TOP);
	assign reverse   = (direction_q == DIR_RIGHT_LEFT) || (direction_q == DIR_BOTTOM_TOP);
	assign dim_sel   = vertical ? height_eff : width_eff;
	assign prog_sel  = reverse ? prog_inv : prog_eff;

	assign split_prod = PROD_BITS'(dim_sel) * PROD_BITS'(prog_sel);
	assign split_pos  = split_prod[PROD_BITS-1:8];
	assign coord_sel  = vertical ? THR_BITS'(row_s1) : THR_BITS'(column_s1);

	// leading edge uses less-than, trailing edge greater-than, so a reverse
	// wipe at full progress still leaves the first column or row
	assign take_second = reverse ? (coord_sel > split_pos) : (coord_sel < split_pos);

	// per-channel cross-fade with truncation
	always_comb begin
		logic [CHAN_BITS+PROG_BITS-1:0] mix;
		fade_pix = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			mix = (CHAN_BITS+PROG_BITS)'(item_s1.pixel_first[c*CHAN_BITS +: CHAN_BITS])
				* (CHAN_BITS+PROG_BITS)'(prog_inv)
				+ (CHAN_BITS+PROG_BITS)'(item_s1.pixel_second[c*CHAN_BITS +: CHAN_BITS])
				* (CHAN_BITS+PROG_BITS)'(prog_eff);
			fade_pix[c*CHAN_BITS +: CHAN_BITS] = mix[CHAN_BITS+7:8];
		end
	end

	assign result_pix = !wipe_mode ? fade_pix :
		(take_second ? item_s1.pixel_second : item_s1.pixel_first);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			item_s2.pixel_out <= result_pix;
			item_s2.line_end  <= line_end_s1;
			item_s2.frame_end <= frame_end_s1;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_item  = item_s2;

endmodule

>>> design/ftc_checker.sv
// ----------------------------------------------------------------------------
// ftc_checker
// port-level checks of the frame transition compositor
// ----------------------------------------------------------------------------
module ftc_checker
	import ftc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     src_valid,
	input logic     src_stall,
	input ftc_in_t  src_item,
	input logic     dst_valid,
	input logic     dst_stall,
	input ftc_out_t dst_item
);

	// stalled input item holds
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_item))
		else $error("stalled input item changed");

	// stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
		else $error("stalled result changed");

	// frame end only on the last pixel of a line
	a_frame_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (!dst_item.frame_end || dst_item.line_end))
		else $error("frame end without line end");

	// input back-pressure only while a result is held up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (dst_valid && dst_stall))
		else $error("input stalled without output back-pressure");

	// a result leaves only through a taken handshake
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dst_valid) |-> $past(!dst_stall))
		else $error("result dropped while stalled");

endmodule

bind frame_transition_compositor_core ftc_checker u_ftc_checker (.*);
